>>> rtl/pusq_pkg.sv
package pusq_pkg;

   localparam int unsigned NUM_SUBSYS = 9;

   // command codes
   localparam logic [3:0] CMD_ADC       = 4'd0;
   localparam logic [3:0] CMD_SOC       = 4'd1;
   localparam logic [3:0] CMD_BALANCE   = 4'd2;
   localparam logic [3:0] CMD_PROTECT   = 4'd3;
   localparam logic [3:0] CMD_MOS       = 4'd4;
   localparam logic [3:0] CMD_RELAY     = 4'd5;
   localparam logic [3:0] CMD_CAN       = 4'd6;
   localparam logic [3:0] CMD_COOL      = 4'd7;
   localparam logic [3:0] CMD_HEAT      = 4'd8;
   localparam logic [3:0] CMD_REINIT    = 4'd9;
   localparam logic [3:0] CMD_SOC_DONE  = 4'd10;
   localparam logic [3:0] CMD_COOL_DONE = 4'd11;
   localparam logic [3:0] CMD_HEAT_DONE = 4'd12;

   // pending bit positions
   localparam int unsigned BIT_ADC     = 0;
   localparam int unsigned BIT_SOC     = 1;
   localparam int unsigned BIT_BALANCE = 2;
   localparam int unsigned BIT_PROTECT = 3;
   localparam int unsigned BIT_MOS     = 4;
   localparam int unsigned BIT_RELAY   = 5;
   localparam int unsigned BIT_CAN     = 6;
   localparam int unsigned BIT_COOL    = 7;
   localparam int unsigned BIT_HEAT    = 8;

   // register indexes
   localparam logic [2:0] REG_ADC_SETTLE     = 3'd0;
   localparam logic [2:0] REG_PROTECT_SETTLE = 3'd1;
   localparam logic [2:0] REG_SWITCH_SETTLE  = 3'd2;
   localparam logic [2:0] REG_EN_BALANCE     = 3'd3;
   localparam logic [2:0] REG_EN_HEAT        = 3'd4;
   localparam logic [2:0] REG_EN_COOL        = 3'd5;
   localparam logic [2:0] REG_EN_SWITCHING   = 3'd6;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef struct packed {
      logic [15:0] adc_settle_ticks;
      logic [15:0] protect_settle_ticks;
      logic [7:0]  switch_settle_ticks;
      logic        enable_balance;
      logic        enable_heat;
      logic        enable_cool;
      logic        enable_switching;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      adc_settle_ticks:     16'd50,
      protect_settle_ticks: 16'd2,
      switch_settle_ticks:  8'd3,
      enable_balance:       1'b1,
      enable_heat:          1'b0,
      enable_cool:          1'b0,
      enable_switching:     1'b1
   };

   typedef struct packed {
      logic [3:0] cmd;
      logic       tick_adc_protect;
      logic       tick_mos;
      logic       tick_relay;
   } item_type;

   typedef struct packed {
      logic                  may_proceed;
      logic                  system_starting;
      logic [NUM_SUBSYS-1:0] pending_mask;
   } result_type;

   function automatic logic [NUM_SUBSYS-1:0] load_flags(cfg_type cfg);
      logic [NUM_SUBSYS-1:0] f;
      f = '1;
      f[BIT_BALANCE] = cfg.enable_balance;
      f[BIT_HEAT]    = cfg.enable_heat;
      f[BIT_COOL]    = cfg.enable_cool;
      f[BIT_MOS]     = cfg.enable_switching;
      f[BIT_RELAY]   = cfg.enable_switching;
      return f;
   endfunction

endpackage

>>> rtl/pusq_if.sv
interface pusq_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] cmd;
   logic       tick_adc_protect;
   logic       tick_mos;
   logic       tick_relay;
   modport source (output valid, cmd, tick_adc_protect, tick_mos, tick_relay, input ready);
   modport sink   (input valid, cmd, tick_adc_protect, tick_mos, tick_relay, output ready);
endinterface

interface pusq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            may_proceed;
   logic                            system_starting;
   logic [pusq_pkg::NUM_SUBSYS-1:0] pending_mask;
   modport source (output valid, may_proceed, system_starting, pending_mask, input ready);
   modport sink   (input valid, may_proceed, system_starting, pending_mask, output ready);
endinterface

interface pusq_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pusq_pkg::CSR_INDEX_W-1:0] index;
   logic [pusq_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/power_up_dependency_sequencer_core.sv
// Power-up dependency sequencer.
// req_bus carries one poll or command per beat (cmd plus three 10 ms tick
// flags). rsp_bus returns exactly one beat per request: may_proceed, the
// system-starting flag and the pending mask after the request took effect.
// csr_bus writes the settle thresholds and enable bits; it is always ready.
// Enable changes only reach the pending flags on reinit.
// Requests pass through an input register and a response register.
// Throughput: one request per cycle while the receiver takes responses;
// the flag/counter update is a single pass of logic between the two.
// When the receiver stalls, the response register holds its beat and the
// input register keeps one more request, after which req_bus.ready drops.
// Reset (synchronous, active high) restores default thresholds and
// enables, loads the pending flags from those defaults, sets the
// system-starting flag, zeroes the counters and empties both registers.
module power_up_dependency_sequencer_core (
   input  logic      clock,
   input  logic      reset,
   pusq_req_if.sink  req_bus,
   pusq_rsp_if.source rsp_bus,
   pusq_csr_if.sink  csr_bus
);

   pusq_pkg::cfg_type    cfg;
   pusq_pkg::item_type   item_ff;
   pusq_pkg::result_type step_res;
   pusq_pkg::result_type res_ff;
   logic                 s1_valid_ff, s2_valid_ff;
   logic                 advance;

   assign advance       = s1_valid_ff && (!s2_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) s1_valid_ff <= req_bus.valid;
         if (advance) s2_valid_ff <= 1'b1;
         else if (rsp_bus.ready) s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         item_ff.cmd              <= req_bus.cmd;
         item_ff.tick_adc_protect <= req_bus.tick_adc_protect;
         item_ff.tick_mos         <= req_bus.tick_mos;
         item_ff.tick_relay       <= req_bus.tick_relay;
      end
      if (advance) res_ff <= step_res;
   end

   pusq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   pusq_state u_state (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (item_ff),
      .result  (step_res)
   );

   assign rsp_bus.valid           = s2_valid_ff;
   assign rsp_bus.may_proceed     = res_ff.may_proceed;
   assign rsp_bus.system_starting = res_ff.system_starting;
   assign rsp_bus.pending_mask    = res_ff.pending_mask;

endmodule

>>> rtl/pusq_csr.sv
module pusq_csr (
   input  logic              clock,
   input  logic              reset,
   pusq_csr_if.sink          csr_bus,
   output pusq_pkg::cfg_type cfg
);

   pusq_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            pusq_pkg::REG_ADC_SETTLE:     cfg_in.adc_settle_ticks     = csr_bus.data;
            pusq_pkg::REG_PROTECT_SETTLE: cfg_in.protect_settle_ticks = csr_bus.data;
            pusq_pkg::REG_SWITCH_SETTLE:  cfg_in.switch_settle_ticks  = csr_bus.data[7:0];
            pusq_pkg::REG_EN_BALANCE:     cfg_in.enable_balance       = csr_bus.data[0];
            pusq_pkg::REG_EN_HEAT:        cfg_in.enable_heat          = csr_bus.data[0];
            pusq_pkg::REG_EN_COOL:        cfg_in.enable_cool          = csr_bus.data[0];
            pusq_pkg::REG_EN_SWITCHING:   cfg_in.enable_switching     = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pusq_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/pusq_state.sv
module pusq_state (
   input  logic                 clock,
   input  logic                 reset,
   input  pusq_pkg::cfg_type    cfg,
   input  logic                 step_en,
   input  pusq_pkg::item_type   item,
   output pusq_pkg::result_type result
);

   logic [pusq_pkg::NUM_SUBSYS-1:0] pend_ff, pend_in;
   logic [15:0] adc_cnt_ff, adc_cnt_in;
   logic [15:0] prot_cnt_ff, prot_cnt_in;
   logic [7:0]  mos_cnt_ff, mos_cnt_in;
   logic [7:0]  rly_cnt_ff, rly_cnt_in;
   logic        start_ff, start_in;
   logic        ok;

   logic [16:0] adc_inc, prot_inc;
   logic [8:0]  mos_inc, rly_inc;
   logic        adc_hit, prot_hit, mos_hit, rly_hit;
   logic        switch_gate;

   assign adc_inc  = {1'b0, adc_cnt_ff} + 17'd1;
   assign prot_inc = {1'b0, prot_cnt_ff} + 17'd1;
   assign mos_inc  = {1'b0, mos_cnt_ff} + 9'd1;
   assign rly_inc  = {1'b0, rly_cnt_ff} + 9'd1;
   assign adc_hit  = adc_inc >= {1'b0, cfg.adc_settle_ticks};
   assign prot_hit = prot_inc >= {1'b0, cfg.protect_settle_ticks};
   assign mos_hit  = mos_inc >= {1'b0, cfg.switch_settle_ticks};
   assign rly_hit  = rly_inc >= {1'b0, cfg.switch_settle_ticks};

   assign switch_gate = !pend_ff[pusq_pkg::BIT_PROTECT] && !pend_ff[pusq_pkg::BIT_COOL] &&
                        !pend_ff[pusq_pkg::BIT_HEAT];

   always_comb begin
      pend_in     = pend_ff;
      adc_cnt_in  = adc_cnt_ff;
      prot_cnt_in = prot_cnt_ff;
      mos_cnt_in  = mos_cnt_ff;
      rly_cnt_in  = rly_cnt_ff;
      start_in    = start_ff;
      ok          = 1'b0;
      // a poll of a subsystem already done just answers 1
      if (item.cmd <= pusq_pkg::CMD_HEAT && !pend_ff[item.cmd]) begin
         ok = 1'b1;
      end else begin
         unique case (item.cmd) inside
            pusq_pkg::CMD_ADC: begin
               if (item.tick_adc_protect) begin
                  if (adc_hit) begin
                     adc_cnt_in = '0;
                     pend_in[pusq_pkg::BIT_ADC] = 1'b0;
                  end else begin
                     adc_cnt_in = adc_inc[15:0];
                  end
               end
            end
            pusq_pkg::CMD_SOC: ok = !pend_ff[pusq_pkg::BIT_ADC];
            pusq_pkg::CMD_BALANCE: begin
               if (!pend_ff[pusq_pkg::BIT_ADC]) pend_in[pusq_pkg::BIT_BALANCE] = 1'b0;
            end
            pusq_pkg::CMD_PROTECT: begin
               if (!pend_ff[pusq_pkg::BIT_ADC] && !pend_ff[pusq_pkg::BIT_SOC]) begin
                  ok = 1'b1;
                  if (item.tick_adc_protect) begin
                     if (prot_hit) begin
                        prot_cnt_in = '0;
                        pend_in[pusq_pkg::BIT_PROTECT] = 1'b0;
                     end else begin
                        prot_cnt_in = prot_inc[15:0];
                     end
                  end
               end
            end
            pusq_pkg::CMD_MOS: begin
               if (switch_gate && item.tick_mos) begin
                  if (mos_hit) begin
                     mos_cnt_in = '0;
                     pend_in[pusq_pkg::BIT_MOS] = 1'b0;
                     start_in = 1'b0;
                  end else begin
                     mos_cnt_in = mos_inc[7:0];
                  end
               end
            end
            pusq_pkg::CMD_RELAY: begin
               if (switch_gate && item.tick_relay) begin
                  if (rly_hit) begin
                     rly_cnt_in = '0;
                     pend_in[pusq_pkg::BIT_RELAY] = 1'b0;
                     start_in = 1'b0;
                  end else begin
                     rly_cnt_in = rly_inc[7:0];
                  end
               end
            end
            pusq_pkg::CMD_CAN: begin
               if (!pend_ff[pusq_pkg::BIT_MOS] || !pend_ff[pusq_pkg::BIT_RELAY])
                  pend_in[pusq_pkg::BIT_CAN] = 1'b0;
            end
            pusq_pkg::CMD_COOL, pusq_pkg::CMD_HEAT: ok = 1'b1;
            pusq_pkg::CMD_REINIT: begin
               pend_in  = pusq_pkg::load_flags(cfg);
               start_in = 1'b1;
            end
            pusq_pkg::CMD_SOC_DONE: begin
               pend_in[pusq_pkg::BIT_SOC] = 1'b0;
               ok = 1'b1;
            end
            pusq_pkg::CMD_COOL_DONE: begin
               pend_in[pusq_pkg::BIT_COOL] = 1'b0;
               ok = 1'b1;
            end
            pusq_pkg::CMD_HEAT_DONE: begin
               pend_in[pusq_pkg::BIT_HEAT] = 1'b0;
               ok = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= pusq_pkg::load_flags(pusq_pkg::CFG_RESET);
         adc_cnt_ff  <= '0;
         prot_cnt_ff <= '0;
         mos_cnt_ff  <= '0;
         rly_cnt_ff  <= '0;
         start_ff    <= 1'b1;
      end else if (step_en) begin
         pend_ff     <= pend_in;
         adc_cnt_ff  <= adc_cnt_in;
         prot_cnt_ff <= prot_cnt_in;
         mos_cnt_ff  <= mos_cnt_in;
         rly_cnt_ff  <= rly_cnt_in;
         start_ff    <= start_in;
      end
   end

   assign result.may_proceed     = ok;
   assign result.system_starting = start_in;
   assign result.pending_mask    = pend_in;

endmodule
